### src/rpb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and fixed-point helpers for the ruin probability bounds core.
// No dependencies.
package rpb_pkg;

    localparam int MAX_LEN   = 64;
    localparam int FRAC_BITS = 30;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = IDX_W + 1;
    localparam int MASS_W    = 31;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DIV_STEPS = 2 * FRAC_BITS;
    localparam int POS_W     = $clog2(DIV_STEPS + 1);
    localparam int QUO_W     = VAL_W - 1;

    localparam logic signed [ACC_W-1:0]  ONE_Q   = ACC_W'(64'd1 << FRAC_BITS);
    localparam logic        [PROD_W-1:0] HALF_Q  = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  S32_MAX = ACC_W'(64'd2147483647);
    localparam logic signed [ACC_W-1:0]  S32_MIN = -S32_MAX - ACC_W'(1);

    typedef enum logic [2:0] {
        OP_CONV,
        OP_REC,
        OP_SCALE,
        OP_MASS,
        OP_QC,
        OP_FAC
    } t_op;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CV_ISSUE,
        S_CV_DRAIN,
        S_QC_ISSUE,
        S_QC_DRAIN,
        S_DIV,
        S_FAC_ISSUE,
        S_FAC_DRAIN,
        S_RC_START,
        S_RC_ISSUE,
        S_RC_DRAIN,
        S_RC_SCALE,
        S_RC_MASS,
        S_RC_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic i_clr;
        logic i_inc;
        logic j_clr;
        logic j_one;
        logic j_inc;
        logic issue;
        t_op  op;
        logic conv_wr;
        logic hold;
        logic div_start;
        logic fac_set;
        logic dens_wr;
    } t_cmd;

    typedef struct packed {
        logic load_last;
        logic j_last;
        logic i_last;
        logic i_zero;
        logic pipe_busy;
        logic div_busy;
        logic out_free;
    } t_sts;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > S32_MAX) begin
            r = S32_MAX[VAL_W-1:0];
        end else if (x < S32_MIN) begin
            r = S32_MIN[VAL_W-1:0];
        end else begin
            r = x[VAL_W-1:0];
        end
        return r;
    endfunction

    // Round a full product to FRAC_BITS fraction bits, half away from zero.
    function automatic logic signed [ACC_W-1:0] fround(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        r   = (mag + HALF_Q) >> FRAC_BITS;
        return p[PROD_W-1] ? -$signed(r[ACC_W-1:0]) : $signed(r[ACC_W-1:0]);
    endfunction

endpackage

### src/rpb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and results.
// Depends on rpb_pkg.
interface rpb_in_if;
    import rpb_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASS_W-1:0] first_low_mass;
    logic [MASS_W-1:0] first_up_mass;
    logic [MASS_W-1:0] second_low_mass;
    logic [MASS_W-1:0] second_up_mass;
    logic              last_index;
    modport source (output valid, first_low_mass, first_up_mass, second_low_mass,
                    second_up_mass, last_index, input ready);
    modport sink (input valid, first_low_mass, first_up_mass, second_low_mass,
                  second_up_mass, last_index, output ready);
endinterface

interface rpb_out_if;
    import rpb_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        position;
    logic signed [VAL_W-1:0] low_density;
    logic signed [VAL_W-1:0] up_density;
    logic signed [VAL_W-1:0] lower_bound;
    logic signed [VAL_W-1:0] upper_bound;
    logic                    final_result;
    modport source (output valid, position, low_density, up_density, lower_bound,
                    upper_bound, final_result, input ready);
    modport sink (input valid, position, low_density, up_density, lower_bound,
                  upper_bound, final_result, output ready);
endinterface

### src/ruin_probability_bounds_core.sv
`timescale 1ns / 1ps
// Ruin probability bounds core. Items are taken one per cycle, during the load phase, into four mass
// stores; the item flagged last (or the 64th) starts a run over n loaded indices.
// The convolution and the recursion each issue one multiply-accumulate per cycle
// from their issue states into a four-stage lane pair, and the 1/(1-q*hl0) factor
// comes from a bit-serial divider of 61 steps that holds the sequencer while busy.
// Results leave one per index through a result register; an index waits while the
// previous result is still held, and the next load starts as soon as the last
// result is registered.
// Depends on rpb_pkg, rpb_if, rpb_ctrl and rpb_datapath.
module ruin_probability_bounds_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [rpb_pkg::MASS_W-1:0] i_cfg_data,
    rpb_in_if.sink             i_in,
    rpb_out_if.source          o_out
);
    import rpb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    rpb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(i_in.valid), .i_sts(w_sts), .o_cmd(w_cmd),
        .o_in_ready(w_in_ready));

    rpb_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts), .i_cfg_we, .i_cfg_data,
        .i_first_low_mass(i_in.first_low_mass), .i_first_up_mass(i_in.first_up_mass),
        .i_second_low_mass(i_in.second_low_mass), .i_second_up_mass(i_in.second_up_mass),
        .i_last_index(i_in.last_index), .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid), .o_position(o_out.position),
        .o_low_density(o_out.low_density), .o_up_density(o_out.up_density),
        .o_lower_bound(o_out.lower_bound), .o_upper_bound(o_out.upper_bound),
        .o_final_result(o_out.final_result));

    assign i_in.ready = w_in_ready;

`ifndef SYNTHESIS
    a_dens_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.dens_wr |-> !w_sts.pipe_busy)
        else $error("density written while lanes still busy");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !w_sts.pipe_busy && !w_sts.div_busy)
        else $error("input taken while a run is active");
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> w_sts.div_busy)
        else $error("divider did not start");
`endif
endmodule

### src/rpb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/rpb_recip.sv
`timescale 1ns / 1ps
// Bit-serial reciprocal unit: 2^(2*FRAC_BITS)/d, rounded and saturated.
// Depends on rpb_pkg.
module rpb_recip (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [rpb_pkg::ACC_W-1:0] i_div,
    output logic                    o_busy,
    output logic signed [rpb_pkg::VAL_W-1:0] o_quot
);
    import rpb_pkg::*;

    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    logic [ACC_W:0]   r_rem;
    logic [ACC_W-1:0] r_dvs;
    logic [QUO_W-1:0] r_quo;
    logic             r_over;
    logic             r_neg;
    logic             r_zero;

    logic [ACC_W:0] w_shift;
    logic           w_ge;
    logic           w_rnd;
    logic [QUO_W:0] w_q;

    assign w_shift = {r_rem[ACC_W-1:0], r_pos == POS_W'(DIV_STEPS)};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_rnd   = {r_rem, 1'b0} >= {2'b00, r_dvs};
    assign w_q     = {1'b0, r_quo} + (QUO_W + 1)'(w_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_pos == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs  <= i_div[ACC_W-1] ? ACC_W'(-i_div) : ACC_W'(i_div);
            r_neg  <= i_div[ACC_W-1];
            r_zero <= i_div == '0;
            r_rem  <= '0;
            r_quo  <= '0;
            r_over <= 1'b0;
            r_pos  <= POS_W'(DIV_STEPS);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_shift - {1'b0, r_dvs};
                if (r_pos >= POS_W'(QUO_W)) begin
                    r_over <= 1'b1;
                end else begin
                    r_quo[r_pos[$clog2(QUO_W)-1:0]] <= 1'b1;
                end
            end else begin
                r_rem <= w_shift;
            end
            if (r_pos != '0) begin
                r_pos <= r_pos - POS_W'(1);
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = S32_MAX[VAL_W-1:0];
        end else if (r_over || w_q[QUO_W]) begin
            o_quot = r_neg ? S32_MIN[VAL_W-1:0] : S32_MAX[VAL_W-1:0];
        end else begin
            o_quot = r_neg ? -$signed(w_q) : $signed(w_q);
        end
    end

    assign o_busy = r_busy;
endmodule

### src/rpb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for load, convolution, reciprocal, recursion and result phases.
// Depends on rpb_pkg.
module rpb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rpb_pkg::t_sts i_sts,
    output rpb_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import rpb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_sts.load_last) n_state = S_CV_ISSUE;
            end
            S_CV_ISSUE: begin
                if (i_sts.j_last) n_state = S_CV_DRAIN;
            end
            S_CV_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = i_sts.i_last ? S_QC_ISSUE : S_CV_ISSUE;
            end
            S_QC_ISSUE: n_state = S_QC_DRAIN;
            S_QC_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_busy) n_state = S_FAC_ISSUE;
            end
            S_FAC_ISSUE: n_state = S_FAC_DRAIN;
            S_FAC_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_RC_START;
            end
            S_RC_START: n_state = i_sts.i_zero ? S_RC_DRAIN : S_RC_ISSUE;
            S_RC_ISSUE: begin
                if (i_sts.j_last) n_state = S_RC_DRAIN;
            end
            S_RC_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_RC_SCALE;
            end
            S_RC_SCALE: n_state = S_RC_MASS;
            S_RC_MASS: n_state = S_RC_FIN;
            S_RC_FIN: begin
                if (!i_sts.pipe_busy && i_sts.out_free) begin
                    n_state = i_sts.i_last ? S_LOAD : S_RC_START;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_CONV;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready  = 1'b1;
                o_cmd.load  = i_in_valid;
                o_cmd.i_clr = 1'b1;
                o_cmd.j_clr = 1'b1;
            end
            S_CV_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.op    = OP_CONV;
                o_cmd.j_inc = !i_sts.j_last;
            end
            S_CV_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.conv_wr = 1'b1;
                    o_cmd.i_inc   = !i_sts.i_last;
                    o_cmd.j_clr   = 1'b1;
                end
            end
            S_QC_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.op    = OP_QC;
            end
            S_QC_DRAIN: o_cmd.div_start = !i_sts.pipe_busy;
            S_DIV: ;
            S_FAC_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.op    = OP_FAC;
            end
            S_FAC_DRAIN: begin
                o_cmd.fac_set = !i_sts.pipe_busy;
                o_cmd.i_clr   = !i_sts.pipe_busy;
            end
            S_RC_START: o_cmd.j_one = 1'b1;
            S_RC_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.op    = OP_REC;
                o_cmd.j_inc = !i_sts.j_last;
            end
            S_RC_DRAIN: o_cmd.hold = !i_sts.pipe_busy;
            S_RC_SCALE: begin
                o_cmd.issue = 1'b1;
                o_cmd.op    = OP_SCALE;
            end
            S_RC_MASS: begin
                o_cmd.issue = 1'b1;
                o_cmd.op    = OP_MASS;
            end
            S_RC_FIN: begin
                if (!i_sts.pipe_busy && i_sts.out_free) begin
                    o_cmd.dens_wr = 1'b1;
                    o_cmd.i_inc   = !i_sts.i_last;
                end
            end
            default: ;
        endcase
    end
endmodule

### src/rpb_datapath.sv
`timescale 1ns / 1ps
// Stores, two multiply-accumulate lanes, scalar factors and result register.
// Depends on rpb_pkg, rpb_ram and rpb_recip.
module rpb_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rpb_pkg::t_cmd           i_cmd,
    output rpb_pkg::t_sts           o_sts,
    input  logic                    i_cfg_we,
    input  logic [rpb_pkg::MASS_W-1:0] i_cfg_data,
    input  logic [rpb_pkg::MASS_W-1:0] i_first_low_mass,
    input  logic [rpb_pkg::MASS_W-1:0] i_first_up_mass,
    input  logic [rpb_pkg::MASS_W-1:0] i_second_low_mass,
    input  logic [rpb_pkg::MASS_W-1:0] i_second_up_mass,
    input  logic                    i_last_index,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [rpb_pkg::IDX_W-1:0] o_position,
    output logic signed [rpb_pkg::VAL_W-1:0] o_low_density,
    output logic signed [rpb_pkg::VAL_W-1:0] o_up_density,
    output logic signed [rpb_pkg::VAL_W-1:0] o_lower_bound,
    output logic signed [rpb_pkg::VAL_W-1:0] o_upper_bound,
    output logic                    o_final_result
);
    import rpb_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_last;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [MASS_W-1:0] r_q;

    logic [IDX_W-1:0] w_diff;
    logic [IDX_W-1:0] w_first_ra;
    logic [IDX_W-1:0] w_conv_ra;

    logic [MASS_W-1:0] w_fl_rd, w_fu_rd, w_sl_rd, w_su_rd;
    logic signed [VAL_W-1:0] w_cl_rd, w_cu_rd, w_dl_rd, w_du_rd;

    logic r_v1, r_v2, r_v3;
    t_op  r_op1;
    logic signed [VAL_W-1:0]  w_al, w_bl, w_au, w_bu;
    logic signed [PROD_W-1:0] r_prod_l, r_prod_u;
    logic signed [ACC_W-1:0]  r_rnd_l, r_rnd_u;
    logic signed [ACC_W-1:0]  r_acc_l, r_acc_u;
    logic                     w_acc_clr;

    logic signed [VAL_W-1:0] r_hold_l, r_hold_u;
    logic signed [VAL_W-1:0] r_qfacl, r_pfacl;
    logic signed [VAL_W-1:0] r_rpl, r_rpu, r_prev_dl;
    logic signed [VAL_W-1:0] w_p, w_facl;
    logic signed [VAL_W-1:0] w_dl, w_du, w_rpl, w_rpu;
    logic                    w_div_busy;
    logic signed [VAL_W-1:0] w_q_s;

    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_o_dl, r_o_du, r_o_lb, r_o_ub;
    logic                    r_o_fin;

    assign w_diff     = r_i - r_j;
    assign w_first_ra = (i_cmd.op == OP_MASS) ? r_i : r_j;
    assign w_conv_ra  = (i_cmd.op == OP_QC) ? '0 : r_j;
    assign w_q_s      = $signed({1'b0, r_q});
    assign w_p        = sat32(ONE_Q - ACC_W'(r_q));

    rpb_ram #(.WIDTH(MASS_W), .DEPTH(MAX_LEN)) u_fl (
        .i_clk, .i_we(i_cmd.load), .i_waddr(r_cnt[IDX_W-1:0]), .i_wdata(i_first_low_mass),
        .i_raddr(w_first_ra), .o_rdata(w_fl_rd));
    rpb_ram #(.WIDTH(MASS_W), .DEPTH(MAX_LEN)) u_fu (
        .i_clk, .i_we(i_cmd.load), .i_waddr(r_cnt[IDX_W-1:0]), .i_wdata(i_first_up_mass),
        .i_raddr(w_first_ra), .o_rdata(w_fu_rd));
    rpb_ram #(.WIDTH(MASS_W), .DEPTH(MAX_LEN)) u_sl (
        .i_clk, .i_we(i_cmd.load), .i_waddr(r_cnt[IDX_W-1:0]), .i_wdata(i_second_low_mass),
        .i_raddr(w_diff), .o_rdata(w_sl_rd));
    rpb_ram #(.WIDTH(MASS_W), .DEPTH(MAX_LEN)) u_su (
        .i_clk, .i_we(i_cmd.load), .i_waddr(r_cnt[IDX_W-1:0]), .i_wdata(i_second_up_mass),
        .i_raddr(w_diff), .o_rdata(w_su_rd));
    rpb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_cl (
        .i_clk, .i_we(i_cmd.conv_wr), .i_waddr(r_i), .i_wdata(sat32(r_acc_l)),
        .i_raddr(w_conv_ra), .o_rdata(w_cl_rd));
    rpb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_cu (
        .i_clk, .i_we(i_cmd.conv_wr), .i_waddr(r_i), .i_wdata(sat32(r_acc_u)),
        .i_raddr(w_conv_ra), .o_rdata(w_cu_rd));
    rpb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_dl (
        .i_clk, .i_we(i_cmd.dens_wr), .i_waddr(r_i), .i_wdata(w_dl),
        .i_raddr(w_diff), .o_rdata(w_dl_rd));
    rpb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_du (
        .i_clk, .i_we(i_cmd.dens_wr), .i_waddr(r_i), .i_wdata(w_du),
        .i_raddr(w_diff), .o_rdata(w_du_rd));

    rpb_recip u_recip (
        .i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_div(ONE_Q - r_acc_l),
        .o_busy(w_div_busy), .o_quot(w_facl));

    // Counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_q   <= '0;
        end else begin
            if (i_cfg_we) r_q <= i_cfg_data;
            if (i_cmd.load) begin
                r_cnt <= o_sts.load_last ? '0 : r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_last <= r_cnt[IDX_W-1:0];
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + IDX_W'(1);
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_one) begin
            r_j <= IDX_W'(1);
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + IDX_W'(1);
        end
    end

    // Operand select, in the cycle after the read address was issued
    always_comb begin
        w_al = '0;
        w_bl = '0;
        w_au = '0;
        w_bu = '0;
        unique case (r_op1)
            OP_CONV: begin
                w_al = $signed({1'b0, w_fl_rd});
                w_bl = $signed({1'b0, w_sl_rd});
                w_au = $signed({1'b0, w_fu_rd});
                w_bu = $signed({1'b0, w_su_rd});
            end
            OP_REC: begin
                w_al = w_cl_rd;
                w_bl = w_dl_rd;
                w_au = w_cu_rd;
                w_bu = w_du_rd;
            end
            OP_SCALE: begin
                w_al = r_hold_l;
                w_bl = r_qfacl;
                w_au = r_hold_u;
                w_bu = w_q_s;
            end
            OP_MASS: begin
                w_al = $signed({1'b0, w_fl_rd});
                w_bl = r_pfacl;
                w_au = $signed({1'b0, w_fu_rd});
                w_bu = w_p;
            end
            OP_QC: begin
                w_al = w_q_s;
                w_bl = w_cl_rd;
            end
            OP_FAC: begin
                w_al = w_q_s;
                w_bl = w_facl;
                w_au = w_p;
                w_bu = w_facl;
            end
            default: ;
        endcase
    end

    assign w_acc_clr = i_cmd.load | i_cmd.conv_wr | i_cmd.hold | i_cmd.div_start
                     | i_cmd.fac_set | i_cmd.dens_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_acc_l <= '0;
            r_acc_u <= '0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (w_acc_clr) begin
                r_acc_l <= '0;
                r_acc_u <= '0;
            end else if (r_v3) begin
                r_acc_l <= r_acc_l + r_rnd_l;
                r_acc_u <= r_acc_u + r_rnd_u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1    <= i_cmd.op;
        r_prod_l <= w_al * w_bl;
        r_prod_u <= w_au * w_bu;
        r_rnd_l  <= fround(r_prod_l);
        r_rnd_u  <= fround(r_prod_u);
    end

    // Scalar factors and running bounds
    assign w_dl  = sat32(r_acc_l);
    assign w_du  = o_sts.i_zero ? '0 : sat32(r_acc_u);
    assign w_rpl = o_sts.i_zero ? r_rpl : sat32(ACC_W'(r_rpl) - ACC_W'(r_prev_dl));
    assign w_rpu = o_sts.i_zero ? r_rpu : sat32(ACC_W'(r_rpu) - ACC_W'(w_du));

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_hold_l <= sat32(r_acc_l);
            r_hold_u <= sat32(r_acc_u);
        end
        if (i_cmd.fac_set) begin
            r_qfacl <= sat32(r_acc_l);
            r_pfacl <= sat32(r_acc_u);
            r_rpl   <= sat32(ONE_Q);
            r_rpu   <= sat32(ONE_Q);
        end else if (i_cmd.dens_wr) begin
            r_rpl     <= w_rpl;
            r_rpu     <= w_rpu;
            r_prev_dl <= w_dl;
        end
    end

    // Result register: a new result loads when the register is empty or as the previous one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.dens_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dens_wr) begin
            r_pos   <= r_i;
            r_o_dl  <= w_dl;
            r_o_du  <= w_du;
            r_o_lb  <= w_rpl;
            r_o_ub  <= w_rpu;
            r_o_fin <= o_sts.i_last;
        end
    end

    always_comb begin
        o_sts.load_last = i_last_index | (r_cnt == CNT_W'(MAX_LEN - 1));
        o_sts.j_last    = r_j == r_i;
        o_sts.i_last    = r_i == r_last;
        o_sts.i_zero    = r_i == '0;
        o_sts.pipe_busy = r_v1 | r_v2 | r_v3;
        o_sts.div_busy  = w_div_busy;
        o_sts.out_free  = !r_out_valid | i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_pos;
    assign o_low_density  = r_o_dl;
    assign o_up_density   = r_o_du;
    assign o_lower_bound  = r_o_lb;
    assign o_upper_bound  = r_o_ub;
    assign o_final_result = r_o_fin;
endmodule
